>>> hdl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types and constants for the PD line-follower steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DUTY_W   = 10;
  localparam int CFG_W    = 10;
  localparam int IDX_W    = 3;
  localparam int ERR_W    = 4;

  // numerator 30*base -/+ n spans -15345..46035
  localparam int NUM_W    = 17;
  localparam int MAG_W    = 16;
  localparam int QUO_W    = DUTY_W + 2;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_LINE_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] CFG_BASE_SPEED     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_GAIN_P         = 3'd2;
  localparam logic [IDX_W-1:0] CFG_GAIN_D         = 3'd3;
  localparam logic [IDX_W-1:0] CFG_DUTY_MAX       = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_LINE_THRESHOLD = 10'd250;
  localparam logic [CFG_W-1:0] RST_BASE_SPEED     = 10'd100;
  localparam logic [CFG_W-1:0] RST_GAIN_P         = 10'd486;
  localparam logic [CFG_W-1:0] RST_GAIN_D         = 10'd109;
  localparam logic [CFG_W-1:0] RST_DUTY_MAX       = 10'd500;

  // line error magnitudes
  localparam logic signed [ERR_W-1:0] ERR_ALL_DARK = 4'sd5;
  localparam logic signed [ERR_W-1:0] ERR_PAIR     = 4'sd3;
  localparam logic signed [ERR_W-1:0] ERR_SINGLE   = 4'sd1;
  localparam logic signed [ERR_W-1:0] ERR_NONE     = 4'sd0;

  // steering divisor and its reciprocal, exact for magnitudes below 2^16
  localparam logic [4:0]       STEER_DIV   = 5'd30;
  localparam logic [MAG_W-1:0] DIV30_MULT  = 16'd34953;
  localparam int               DIV30_SHIFT = 20;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] middle_sample;
    logic [SAMPLE_W-1:0] right_sample;
  } lfpd_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic signed [ERR_W-1:0] line_error;
    logic                    duty_clamped;
  } lfpd_out_t;

endpackage

`default_nettype wire

>>> hdl/lfpd_duty_calc.sv
// ----------------------------------------------------------------------------
// lfpd_duty_calc
// Divides one steering numerator by 30 (truncating toward zero) and clamps
// the quotient to 0..duty_max.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_duty_calc (
  input  wire logic signed [lfpd_pkg::NUM_W-1:0]  num_i,
  input  wire logic        [lfpd_pkg::DUTY_W-1:0] duty_max_i,
  output      logic        [lfpd_pkg::DUTY_W-1:0] duty_o,
  output      logic                               hit_o
);
  import lfpd_pkg::*;

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [31:0]      prod;
  logic [QUO_W-1:0] quo;

  always_comb begin
    neg  = num_i[NUM_W-1];
    mag  = neg ? MAG_W'(-num_i) : MAG_W'(num_i);
    prod = 32'(mag) * 32'(DIV30_MULT);
    quo  = prod[DIV30_SHIFT +: QUO_W];

    // negative quotient clamps to zero; -29..-1 truncates to zero exactly
    if (neg && (quo != '0)) begin
      duty_o = '0;
      hit_o  = 1'b1;
    end else if (quo > QUO_W'(duty_max_i)) begin
      duty_o = duty_max_i;
      hit_o  = 1'b1;
    end else begin
      duty_o = DUTY_W'(quo);
      hit_o  = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/line_follow_pd_steering.sv
// pipeline: an accepted item passes through stage 1 and then the result register to out_valid_o
// throughput: one item per cycle; in_ready_o drops only when both the error
//   stage and the result register hold items and out_ready_i is low
// the last-error feedback register updates on each accepted item, so it sets no gap between items
// reset: config registers return to their defaults, last error clears to 0,
//   both pipeline stages empty; config writes are always accepted
// ----------------------------------------------------------------------------
// line_follow_pd_steering
// Three-sensor line detector with proportional-derivative motor steering.
// Stage 1 decodes the line error and forms the steering numerators, stage 2
// divides by 30 and clamps into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_pd_steering #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // sample items
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire lfpd_pkg::lfpd_in_t           in_data_i,
  // result items
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      lfpd_pkg::lfpd_out_t          out_data_o,
  // register writes
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [lfpd_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [lfpd_pkg::CFG_W-1:0]   cfg_data_i
);
  import lfpd_pkg::*;

  // samples wider than the field use the whole field
  localparam int MaskBits = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SampleMask = SAMPLE_W'((33'd1 << MaskBits) - 33'd1);

  // configuration registers
  logic [CFG_W-1:0] threshold_q, base_q, gain_p_q, gain_d_q, duty_max_q;

  // line error feedback
  logic signed [ERR_W-1:0] last_err_q, err_d;

  // stage 1: decoded error and numerators
  logic                    s1_valid_q;
  logic signed [ERR_W-1:0] s1_err_q;
  logic signed [NUM_W-1:0] s1_num_l_q, s1_num_r_q, num_l_d, num_r_d;

  // stage 2: result register
  logic      out_valid_q;
  lfpd_out_t out_q;

  logic in_fire, out_adv;
  logic dark_l, dark_m, dark_r;

  logic signed [ERR_W:0]   err_diff;
  logic signed [14:0]      prod_p;
  logic signed [15:0]      prod_d;
  logic signed [NUM_W-1:0] steer_n;
  logic [14:0]             base30;

  logic [DUTY_W-1:0] duty_l, duty_r;
  logic              hit_l, hit_r;

  // handshake: result register frees when empty or taken
  assign out_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || out_adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // config writes, out-of-range index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= RST_LINE_THRESHOLD;
      base_q      <= RST_BASE_SPEED;
      gain_p_q    <= RST_GAIN_P;
      gain_d_q    <= RST_GAIN_D;
      duty_max_q  <= RST_DUTY_MAX;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LINE_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_BASE_SPEED:     base_q      <= cfg_data_i;
        CFG_GAIN_P:         gain_p_q    <= cfg_data_i;
        CFG_GAIN_D:         gain_d_q    <= cfg_data_i;
        CFG_DUTY_MAX:       duty_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // line detection: a sample below threshold is over the line
  always_comb begin
    dark_l = (in_data_i.left_sample   & SampleMask) < threshold_q;
    dark_m = (in_data_i.middle_sample & SampleMask) < threshold_q;
    dark_r = (in_data_i.right_sample  & SampleMask) < threshold_q;

    // priority decode; all dark keeps the side of the previous error
    if (dark_l && dark_m && dark_r) begin
      err_d = last_err_q[ERR_W-1] ? -ERR_ALL_DARK : ERR_ALL_DARK;
    end else if (dark_l && dark_m) begin
      err_d = -ERR_PAIR;
    end else if (dark_l) begin
      err_d = -ERR_SINGLE;
    end else if (dark_r && dark_m) begin
      err_d = ERR_PAIR;
    end else if (dark_r) begin
      err_d = ERR_SINGLE;
    end else begin
      err_d = ERR_NONE;
    end
  end

  // pd term: small gain products, zero when on course
  always_comb begin
    err_diff = (ERR_W+1)'(err_d) - (ERR_W+1)'(last_err_q);
    prod_p   = $signed({1'b0, gain_p_q}) * err_d;
    prod_d   = $signed({1'b0, gain_d_q}) * err_diff;
    steer_n  = (err_d == ERR_NONE) ? '0 : (NUM_W'(prod_p) + NUM_W'(prod_d));
    base30   = 15'(base_q) * 15'(STEER_DIV);
    num_l_d  = $signed({2'b00, base30}) - steer_n;
    num_r_d  = $signed({2'b00, base30}) + steer_n;
  end

  // last error and stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= ERR_NONE;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        last_err_q <= err_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_err_q   <= err_d;
      s1_num_l_q <= num_l_d;
      s1_num_r_q <= num_r_d;
    end
  end

  // divide by 30 and clamp, one unit per motor
  lfpd_duty_calc u_duty_left (
    .num_i      (s1_num_l_q),
    .duty_max_i (duty_max_q),
    .duty_o     (duty_l),
    .hit_o      (hit_l)
  );

  lfpd_duty_calc u_duty_right (
    .num_i      (s1_num_r_q),
    .duty_max_i (duty_max_q),
    .duty_o     (duty_r),
    .hit_o      (hit_r)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_q.left_duty    <= duty_l;
      out_q.right_duty   <= duty_r;
      out_q.line_error   <= s1_err_q;
      out_q.duty_clamped <= hit_l || hit_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/lfpd_checker.sv
// ----------------------------------------------------------------------------
// lfpd_checker
// Port-level checks for the PD line-follower steering block.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire lfpd_pkg::lfpd_out_t out_data_o
);
  import lfpd_pkg::*;

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

  // error is one of the decoded line positions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.line_error == -ERR_ALL_DARK ||
                     out_data_o.line_error == -ERR_PAIR ||
                     out_data_o.line_error == -ERR_SINGLE ||
                     out_data_o.line_error == ERR_NONE ||
                     out_data_o.line_error == ERR_SINGLE ||
                     out_data_o.line_error == ERR_PAIR ||
                     out_data_o.line_error == ERR_ALL_DARK))
    else $error("line error outside decoded set");

  // on course both motors get the same duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.line_error == ERR_NONE) |->
      out_data_o.left_duty == out_data_o.right_duty)
    else $error("unequal duties with zero error");

  // an empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // an accepted item with a free output reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("accepted item lost in pipeline");

endmodule

bind line_follow_pd_steering lfpd_checker u_lfpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> sim/steering_checker.sv
// ----------------------------------------------------------------------------
// steering_checker
// Watches the sample, result and register channels of the PD steering block,
// predicts each result and compares it with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module steering_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  lfpd_pkg::lfpd_in_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  lfpd_pkg::lfpd_out_t          out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [lfpd_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [lfpd_pkg::CFG_W-1:0]   cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           clamped_o
);

  import lfpd_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [CFG_W-1:0]        line_thr;
  logic [CFG_W-1:0]        base_duty;
  logic [CFG_W-1:0]        kp;
  logic [CFG_W-1:0]        kd;
  logic [CFG_W-1:0]        duty_ceiling;
  logic signed [ERR_W-1:0] prev_error;

  lfpd_out_t steer_q[$];
  int        fails   = 0;
  int        checked = 0;
  int        clamped = 0;

  // line error from the dark flags, then PD steering around the base duty
  function automatic lfpd_out_t steering_for(input lfpd_in_t s,
                                             input logic signed [ERR_W-1:0] prev);
    lfpd_out_t r;
    logic      dl, dm, dr, hit;
    int        err, n, b30, lduty, rduty;
    dl  = s.left_sample < line_thr;
    dm  = s.middle_sample < line_thr;
    dr  = s.right_sample < line_thr;
    hit = 1'b0;
    if (dl && dm && dr) begin
      err = (prev < 0) ? -int'(ERR_ALL_DARK) : int'(ERR_ALL_DARK);
    end else if (dl && dm) begin
      err = -int'(ERR_PAIR);
    end else if (dl) begin
      err = -int'(ERR_SINGLE);
    end else if (dr && dm) begin
      err = int'(ERR_PAIR);
    end else if (dr) begin
      err = int'(ERR_SINGLE);
    end else begin
      err = int'(ERR_NONE);
    end
    if (err != 0) begin
      n     = int'(kp) * err + int'(kd) * (err - int'(prev));
      b30   = int'(STEER_DIV) * int'(base_duty);
      lduty = (b30 - n) / int'(STEER_DIV);
      rduty = (b30 + n) / int'(STEER_DIV);
    end else begin
      lduty = int'(base_duty);
      rduty = int'(base_duty);
    end
    if (lduty < 0) begin
      lduty = 0;
      hit   = 1'b1;
    end else if (lduty > int'(duty_ceiling)) begin
      lduty = int'(duty_ceiling);
      hit   = 1'b1;
    end
    if (rduty < 0) begin
      rduty = 0;
      hit   = 1'b1;
    end else if (rduty > int'(duty_ceiling)) begin
      rduty = int'(duty_ceiling);
      hit   = 1'b1;
    end
    r.left_duty    = DUTY_W'(lduty);
    r.right_duty   = DUTY_W'(rduty);
    r.line_error   = ERR_W'(err);
    r.duty_clamped = hit;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lfpd_out_t want, got;
    if (!rst_ni) begin
      line_thr     <= RST_LINE_THRESHOLD;
      base_duty    <= RST_BASE_SPEED;
      kp           <= RST_GAIN_P;
      kd           <= RST_GAIN_D;
      duty_ceiling <= RST_DUTY_MAX;
      prev_error   <= '0;
      steer_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
      checked_o    <= 0;
      clamped_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LINE_THRESHOLD: line_thr     <= cfg_data_i;
          CFG_BASE_SPEED:     base_duty    <= cfg_data_i;
          CFG_GAIN_P:         kp           <= cfg_data_i;
          CFG_GAIN_D:         kd           <= cfg_data_i;
          CFG_DUTY_MAX:       duty_ceiling <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        want = steering_for(in_data_i, prev_error);
        prev_error <= want.line_error;
        steer_q.push_back(want);
        if (want.duty_clamped) clamped++;
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        checked++;
        if (steer_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected result: left %0d right %0d error %0d clamp %0b",
                     got.left_duty, got.right_duty, got.line_error, got.duty_clamped);
        end else begin
          want = steer_q.pop_front();
          if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
              got.line_error !== want.line_error ||
              got.duty_clamped !== want.duty_clamped) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("result %0d: expected left %0d right %0d error %0d clamp %0b, %s",
                       checked, want.left_duty, want.right_duty, want.line_error,
                       want.duty_clamped,
                       $sformatf("got left %0d right %0d error %0d clamp %0b",
                                 got.left_duty, got.right_duty, got.line_error,
                                 got.duty_clamped));
          end
        end
      end
      pending_o    <= steer_q.size();
      fail_count_o <= fails;
      checked_o    <= checked;
      clamped_o    <= clamped;
    end
  end

endmodule

>>> sim/line_follow_pd_steering_test.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steering_test
// Drives sensor sample items into the PD steering block under several register
// settings and random handshake gaps; a checker beside the block predicts the
// motor duties and line error of every item and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module line_follow_pd_steering_test;

  import lfpd_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 3;
  // two pipeline stages, plus a little margin
  localparam int DRAIN_CYCLES    = 4;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int HOLD_PHASE      = 4;
  localparam int HOLD_CYCLES     = 64;
  localparam int LIMIT_NS        = 2_000_000;
  localparam int NUM_DIRECTED    = 20;

  // sample sets run at the reset register values: every error rule, the
  // threshold boundary, field extremes and alternating bit patterns
  localparam logic [3*SAMPLE_W-1:0] DIRECTED [NUM_DIRECTED] = '{
    {10'd1023, 10'd1023, 10'd1023},   // nothing dark
    {10'd0,    10'd0,    10'd0   },   // all dark after zero error
    {10'd0,    10'd0,    10'd1023},   // left and middle
    {10'd0,    10'd0,    10'd0   },   // all dark after a negative error
    {10'd100,  10'd1023, 10'd1023},   // left alone
    {10'd1023, 10'd0,    10'd0   },   // right and middle
    {10'd0,    10'd0,    10'd0   },   // all dark after a positive error
    {10'd1023, 10'd1023, 10'd0   },   // right alone
    {10'd1023, 10'd0,    10'd1023},   // middle alone gives no error
    {10'd0,    10'd1023, 10'd0   },   // left and right, left wins
    {10'd249,  10'd250,  10'd1023},   // just below and at the threshold
    {10'd250,  10'd249,  10'd249 },
    {10'd250,  10'd250,  10'd250 },
    {10'd0,    10'd0,    10'd0   },
    {10'd1023, 10'd1023, 10'd1023},
    {10'd682,  10'd341,  10'd682 },   // alternating bits
    {10'd341,  10'd682,  10'd341 },
    {10'd0,    10'd1023, 10'd1023},
    {10'd1023, 10'd1023, 10'd0   },   // swing from left to right
    {10'd0,    10'd0,    10'd0   }
  };

  typedef struct packed {
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] kd;
    logic [CFG_W-1:0] dmax;
  } steer_regs_t;

  // block inputs, known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  lfpd_in_t         in_data_i   = '0;
  logic             out_ready_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  // block outputs
  logic      in_ready_o;
  logic      out_valid_o;
  lfpd_out_t out_data_o;
  logic      cfg_ready_o;

  // checker outputs
  int fail_count;
  int pending;
  int checked;
  int clamped;

  // handshake shaping
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_go       = 1'b0;
  logic stall_rx      = 1'b0;

  int items_sent    = 0;
  int settings_used = 1;

  line_follow_pd_steering DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  steering_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clamped_o    (clamped)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // result side: random back-pressure, forced low during a hold-off
  always @(posedge clk_i) begin
    out_ready_i <= !stall_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted here so the sender keeps offering items
  // and the pipeline fills until in_ready_o drops
  initial begin
    wait (hold_go);
    stall_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_rx <= 1'b0;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", pending);
    $display("line_follow_pd_steering_test NOT OK");
    $finish;
  end

  // one sensor level, dark or light against the current threshold
  function automatic logic [SAMPLE_W-1:0] sensor_level(input logic dark,
                                                       input logic [CFG_W-1:0] thr);
    if (dark && thr != 0) begin
      return SAMPLE_W'($urandom_range(int'(thr) - 1, 0));
    end else if (!dark || thr == 0) begin
      return SAMPLE_W'($urandom_range(1023, int'(thr)));
    end
    return '0;
  endfunction

  // mostly a chosen dark pattern with random levels, some raw noise
  function automatic lfpd_in_t random_samples(input logic [CFG_W-1:0] thr);
    lfpd_in_t   s;
    logic [2:0] dark;
    dark = 3'($urandom_range(7));
    if ($urandom_range(99) < 20) begin
      s = lfpd_in_t'($urandom);
    end else begin
      s.left_sample   = sensor_level(dark[2], thr);
      s.middle_sample = sensor_level(dark[1], thr);
      s.right_sample  = sensor_level(dark[0], thr);
    end
    return s;
  endfunction

  // optional idle cycles, then hold the item until it is taken
  task automatic offer_sample(input lfpd_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // pending is registered in the checker, so wait for the next clock edge before reading it
  task automatic wait_for_drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input steer_regs_t rs);
    wait_for_drain();
    write_reg(CFG_LINE_THRESHOLD, rs.thr);
    write_reg(CFG_BASE_SPEED, rs.base);
    write_reg(CFG_GAIN_P, rs.kp);
    write_reg(CFG_GAIN_D, rs.kd);
    write_reg(CFG_DUTY_MAX, rs.dmax);
    // an index past the register file must leave everything alone
    write_reg(IDX_W'(int'(CFG_DUTY_MAX) + 1 + $urandom_range(2)), CFG_W'($urandom));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic steer_regs_t phase_regs(input int ph);
    steer_regs_t rs;
    case (ph)
      0: rs = '{thr: 10'd1023, base: 10'd1023, kp: 10'd1023, kd: 10'd1023, dmax: 10'd1023};
      // nothing can be dark with a zero threshold
      1: rs = '{thr: 10'd0, base: 10'd0, kp: 10'd0, kd: 10'd0, dmax: 10'd1};
      // zero ceiling pins both duties at zero
      2: rs = '{thr: 10'd300, base: 10'd500, kp: 10'd700, kd: 10'd900, dmax: 10'd0};
      // base above the ceiling clamps even on course
      3: rs = '{thr: 10'd600, base: 10'd900, kp: 10'd1023, kd: 10'd0, dmax: 10'd400};
      default: begin
        rs.thr  = CFG_W'($urandom_range(1023, 1));
        rs.base = CFG_W'($urandom);
        rs.kp   = CFG_W'($urandom);
        rs.kd   = CFG_W'($urandom);
        rs.dmax = CFG_W'($urandom_range(1023, 1));
      end
    endcase
    return rs;
  endfunction

  initial begin
    steer_regs_t rs;
    // sender idles lightly and receiver heavily to begin with
    send_idle_pct <= 25;
    recv_idle_pct <= 80;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sets against the reset register values
    for (int k = 0; k < NUM_DIRECTED; k++) offer_sample(lfpd_in_t'(DIRECTED[k]));
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // light sender / busy receiver, then the reverse, then no gaps at all
      if (ph < 2) begin
        send_idle_pct <= 25;
        recv_idle_pct <= 80;
      end else if (ph < 4) begin
        send_idle_pct <= 80;
        recv_idle_pct <= 25;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      rs = phase_regs(ph);
      program_regs(rs);
      if (ph == HOLD_PHASE) hold_go <= 1'b1;
      repeat (ITEMS_PER_PHASE) offer_sample(random_samples(rs.thr));
      in_valid_i <= 1'b0;
    end

    wait_for_drain();
    $display("ran %0d sample items through %0d register settings, %0d results compared",
             items_sent, settings_used, checked);
    $display("%0d results had a duty saturated, %0d mismatches", clamped, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("line_follow_pd_steering_test OK");
    end else begin
      $display("line_follow_pd_steering_test NOT OK");
    end
    $finish;
  end

endmodule
